FILE: src/pis_pkg.sv
// pis_pkg: widths, payload types, register indexes and shared helpers for the
// pid_integral_separation block. Depends on nothing.

package pis_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int ERR_W      = DATA_WIDTH + 1;
	localparam int DIFF_W     = DATA_WIDTH + 2;
	localparam int GAIN_W     = 24;
	localparam int FRAC_W     = 16;
	localparam int LIMIT_W    = 31;
	localparam int DRIVE_W    = 32;
	localparam int ISUM_W     = 40;
	localparam int MUL_W      = DIFF_W + GAIN_W;
	localparam int PROD_W     = MUL_W - FRAC_W;
	localparam int TERM_W     = PROD_W + 1;
	localparam int ACC_W      = TERM_W + 1;
	localparam int SUM_W      = TERM_W + 2;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P           = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I           = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D           = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT   = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT     = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] CFG_SEPARATION_LIMIT = CFG_IDX_W'(5);

	localparam logic signed [ISUM_W-1:0] ISUM_MAX = {1'b0, {(ISUM_W-1){1'b1}}};
	localparam logic signed [ISUM_W-1:0] ISUM_MIN = {1'b1, {(ISUM_W-1){1'b0}}};

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] setpoint;
		logic signed [DATA_WIDTH-1:0] measured;
	} in_item_t;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] drive;
		logic                      drive_clipped;
		logic                      integral_used;
	} out_item_t;

	// error compared against the separation band
	typedef struct packed {
		logic above_sep;
		logic below_sep;
		logic neg;
		logic pos;
	} err_flags_t;

	function automatic logic signed [TERM_W-1:0] signed_term(
		input logic [PROD_W-1:0] mag,
		input logic              neg
	);
		logic signed [TERM_W-1:0] t;
		t = $signed({1'b0, mag});
		return neg ? -t : t;
	endfunction

endpackage

FILE: src/pid_integral_separation.sv
// pid_integral_separation: top level of the fixed-point pid controller with
// integral separation and anti-windup. Depends on pis_pkg, pis_gain_mul,
// pis_integrator and pis_drive_sat.
//
// Usage:
//   Input channel (in_valid, in_stall, in_item) carries one setpoint and one
//   measured sample per item, signed Q16.16. Output channel (out_valid,
//   out_stall, out_item) returns one drive value per item, with clip and
//   integral-used flags. An item moves on an edge where valid is high and
//   stall is low.
//   Registers are written over cfg_wr_en / cfg_index / cfg_data, one write per
//   edge, and are to be changed only while no item is in flight.
//   Stages: error and its difference, gain products, integral update with p+d
//   sum, final sum and saturation into the result register. Throughput is one
//   item per cycle while out_stall is low; the integral recurrence closes inside
//   the single integrator stage.
//   Each stage holds its item only when the stage after it is full and held,
//   so with out_stall high the block still takes up to four more items.
//   Reset clears all registers, the previous error and the integral sum, and
//   empties the pipeline.

module pid_integral_separation (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic        [pis_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [pis_pkg::LIMIT_W-1:0]   cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  pis_pkg::in_item_t                    in_item,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output pis_pkg::out_item_t                   out_item
);

	logic [pis_pkg::GAIN_W-1:0]  gain_p_q;
	logic [pis_pkg::GAIN_W-1:0]  gain_i_q;
	logic [pis_pkg::GAIN_W-1:0]  gain_d_q;
	logic [pis_pkg::LIMIT_W-1:0] integral_limit_q;
	logic [pis_pkg::LIMIT_W-1:0] output_limit_q;
	logic [pis_pkg::LIMIT_W-1:0] separation_limit_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en1, en2, en3, en4;

	logic signed [pis_pkg::ERR_W-1:0]  err_c;
	logic signed [pis_pkg::ERR_W-1:0]  err_s1;
	logic signed [pis_pkg::ERR_W-1:0]  prev_err_q;
	logic signed [pis_pkg::DIFF_W-1:0] diff_s1;
	logic signed [pis_pkg::ERR_W-1:0]  sep;
	pis_pkg::err_flags_t               flags_s2;

	logic [pis_pkg::PROD_W-1:0] pprod_s2, iprod_s2, dprod_s2;
	logic                       pneg_s2, ineg_s2, dneg_s2;

	logic signed [pis_pkg::SUM_W-1:0]  pd_s3;
	logic signed [pis_pkg::ISUM_W-1:0] integ_s3;
	logic                              used_s3;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q           <= '0;
			gain_i_q           <= '0;
			gain_d_q           <= '0;
			integral_limit_q   <= '0;
			output_limit_q     <= '0;
			separation_limit_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				pis_pkg::CFG_GAIN_P:           gain_p_q <= cfg_data[pis_pkg::GAIN_W-1:0];
				pis_pkg::CFG_GAIN_I:           gain_i_q <= cfg_data[pis_pkg::GAIN_W-1:0];
				pis_pkg::CFG_GAIN_D:           gain_d_q <= cfg_data[pis_pkg::GAIN_W-1:0];
				pis_pkg::CFG_INTEGRAL_LIMIT:   integral_limit_q   <= cfg_data;
				pis_pkg::CFG_OUTPUT_LIMIT:     output_limit_q     <= cfg_data;
				pis_pkg::CFG_SEPARATION_LIMIT: separation_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// a stage loads when it is empty or the next stage loads
	assign en4      = !valid_s4 || !out_stall;
	assign en3      = !valid_s3 || en4;
	assign en2      = !valid_s2 || en3;
	assign en1      = !valid_s1 || en2;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= in_valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
		end
	end

	// stage 1: error and change of error
	assign err_c = pis_pkg::ERR_W'($signed(in_item.setpoint))
		- pis_pkg::ERR_W'($signed(in_item.measured));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
		end else if (en1 && in_valid) begin
			prev_err_q <= err_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			err_s1  <= err_c;
			diff_s1 <= pis_pkg::DIFF_W'(err_c) - pis_pkg::DIFF_W'(prev_err_q);
		end
	end

	// stage 2: gain products and separation band
	assign sep = $signed(pis_pkg::ERR_W'(separation_limit_q));

	always_ff @(posedge clk) begin
		if (en2 && valid_s1) begin
			flags_s2.above_sep <= err_s1 > sep;
			flags_s2.below_sep <= err_s1 < -sep;
			flags_s2.neg       <= err_s1[pis_pkg::ERR_W-1];
			flags_s2.pos       <= !err_s1[pis_pkg::ERR_W-1] && (err_s1 != '0);
		end
	end

	pis_gain_mul u_mul_p (
		.clk     (clk),
		.en      (en2 && valid_s1),
		.value   (pis_pkg::DIFF_W'(err_s1)),
		.gain    (gain_p_q),
		.prod_s2 (pprod_s2),
		.neg_s2  (pneg_s2)
	);

	pis_gain_mul u_mul_i (
		.clk     (clk),
		.en      (en2 && valid_s1),
		.value   (pis_pkg::DIFF_W'(err_s1)),
		.gain    (gain_i_q),
		.prod_s2 (iprod_s2),
		.neg_s2  (ineg_s2)
	);

	pis_gain_mul u_mul_d (
		.clk     (clk),
		.en      (en2 && valid_s1),
		.value   (diff_s1),
		.gain    (gain_d_q),
		.prod_s2 (dprod_s2),
		.neg_s2  (dneg_s2)
	);

	// stage 3: integral update beside the p+d sum
	always_ff @(posedge clk) begin
		if (en3 && valid_s2) begin
			pd_s3 <= pis_pkg::SUM_W'(pis_pkg::signed_term(pprod_s2, pneg_s2))
				+ pis_pkg::SUM_W'(pis_pkg::signed_term(dprod_s2, dneg_s2));
		end
	end

	pis_integrator u_integ (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en3 && valid_s2),
		.iprod    (iprod_s2),
		.ineg     (ineg_s2),
		.flags    (flags_s2),
		.limit    (integral_limit_q),
		.integ_s3 (integ_s3),
		.used_s3  (used_s3)
	);

	// stage 4: final sum, saturation, result register
	pis_drive_sat u_sat (
		.clk         (clk),
		.en          (en4 && valid_s3),
		.pd          (pd_s3),
		.integ       (integ_s3),
		.used        (used_s3),
		.limit       (output_limit_q),
		.out_item_s4 (out_item)
	);

	assign out_valid = valid_s4;

endmodule

FILE: src/pis_gain_mul.sv
// pis_gain_mul: sign-magnitude gain product, |value|*gain/65536 truncated,
// registered with the sign of the value. Depends on pis_pkg.

module pis_gain_mul (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [pis_pkg::DIFF_W-1:0]  value,
	input  logic        [pis_pkg::GAIN_W-1:0]  gain,
	output logic        [pis_pkg::PROD_W-1:0]  prod_s2,
	output logic                               neg_s2
);

	logic                          neg;
	logic [pis_pkg::DIFF_W-1:0]    mag;
	logic [pis_pkg::MUL_W-1:0]     full;

	assign neg  = value[pis_pkg::DIFF_W-1];
	assign mag  = neg ? (~value + 1'b1) : value;
	assign full = pis_pkg::MUL_W'(mag) * pis_pkg::MUL_W'(gain);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= full[pis_pkg::MUL_W-1:pis_pkg::FRAC_W];
			neg_s2  <= neg;
		end
	end

endmodule

FILE: src/pis_integrator.sv
// pis_integrator: integral state with clamp to the limit, separation band and
// one-sided accumulation beyond the limit. Depends on pis_pkg.

module pis_integrator (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic        [pis_pkg::PROD_W-1:0]  iprod,
	input  logic                               ineg,
	input  pis_pkg::err_flags_t                flags,
	input  logic        [pis_pkg::LIMIT_W-1:0] limit,
	output logic signed [pis_pkg::ISUM_W-1:0]  integ_s3,
	output logic                               used_s3
);

	logic signed [pis_pkg::ISUM_W-1:0] isum_q;
	logic signed [pis_pkg::ISUM_W-1:0] lim;
	logic signed [pis_pkg::ISUM_W-1:0] nlim;
	logic signed [pis_pkg::ISUM_W-1:0] base;
	logic signed [pis_pkg::ISUM_W-1:0] sat;
	logic signed [pis_pkg::ISUM_W-1:0] isum_next;
	logic signed [pis_pkg::TERM_W-1:0] iterm;
	logic signed [pis_pkg::ACC_W-1:0]  wide;
	logic                              above;
	logic                              below;
	logic                              used;
	logic                              add_en;

	assign lim   = $signed(pis_pkg::ISUM_W'(limit));
	assign nlim  = -lim;
	assign above = isum_q > lim;
	assign below = isum_q < nlim;
	assign iterm = pis_pkg::signed_term(iprod, ineg);

	always_comb begin
		if (above) begin
			base   = lim;
			used   = !flags.above_sep;
			add_en = !flags.above_sep && flags.neg;
		end else if (below) begin
			base   = nlim;
			used   = !flags.below_sep;
			add_en = !flags.below_sep && flags.pos;
		end else begin
			base   = isum_q;
			used   = !(flags.above_sep || flags.below_sep);
			add_en = used;
		end
		wide = pis_pkg::ACC_W'(base) + pis_pkg::ACC_W'(iterm);
		if (wide > pis_pkg::ACC_W'(pis_pkg::ISUM_MAX)) begin
			sat = pis_pkg::ISUM_MAX;
		end else if (wide < pis_pkg::ACC_W'(pis_pkg::ISUM_MIN)) begin
			sat = pis_pkg::ISUM_MIN;
		end else begin
			sat = wide[pis_pkg::ISUM_W-1:0];
		end
		isum_next = add_en ? sat : base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			isum_q <= '0;
		end else if (en) begin
			isum_q <= isum_next;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			integ_s3 <= used ? isum_next : '0;
			used_s3  <= used;
		end
	end

endmodule

FILE: src/pis_drive_sat.sv
// pis_drive_sat: final sum of the terms, saturation to the output limit and
// the result register. Depends on pis_pkg.

module pis_drive_sat (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [pis_pkg::SUM_W-1:0]   pd,
	input  logic signed [pis_pkg::ISUM_W-1:0]  integ,
	input  logic                               used,
	input  logic        [pis_pkg::LIMIT_W-1:0] limit,
	output pis_pkg::out_item_t                 out_item_s4
);

	logic signed [pis_pkg::SUM_W-1:0] total;
	logic signed [pis_pkg::SUM_W-1:0] lim;
	logic signed [pis_pkg::SUM_W-1:0] clamped;
	logic                             clip;

	assign total = pd + pis_pkg::SUM_W'(integ);
	assign lim   = $signed(pis_pkg::SUM_W'(limit));

	always_comb begin
		clip    = 1'b1;
		clamped = total;
		if (total > lim) begin
			clamped = lim;
		end else if (total < -lim) begin
			clamped = -lim;
		end else begin
			clip = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_item_s4.drive         <= clamped[pis_pkg::DRIVE_W-1:0];
			out_item_s4.drive_clipped <= clip;
			out_item_s4.integral_used <= used;
		end
	end

endmodule

FILE: src/pis_checker.sv
// pis_checker: port-level assertions for pid_integral_separation, bound to
// the top level. Depends on pis_pkg.

module pis_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_stall,
	input logic                                 out_valid,
	input logic                                 out_stall,
	input pis_pkg::out_item_t                   out_item
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("held result changed");

	// with no result waiting the pipeline can always move
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	// an accepted item reaches the output while out_stall stays low
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
		|=> out_valid)
		else $error("item did not reach the output in time");

	// the input is never stalled while a result drains
	a_no_spurious_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |-> !in_stall)
		else $error("input stalled while output drains");

endmodule

bind pid_integral_separation pis_checker u_pis_checker (.*);
